### src/column_post_picture_decoder_unit_defines.svh
// assertion macros shared by the decoder rtl
`ifndef COLUMN_POST_PICTURE_DECODER_UNIT_DEFINES_SVH
`define COLUMN_POST_PICTURE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define CPPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cppd assertion failed");

// next-cycle implication
`define CPPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cppd assertion failed");

`endif

### src/cppd_pkg.sv
package cppd_pkg;

	// lump memory geometry
	localparam int ADDR_W     = 16;
	localparam int LUMP_BYTES = 1 << ADDR_W;
	localparam int LEN_W      = ADDR_W + 1;
	localparam int POS_W      = LEN_W + 1;
	localparam logic [LEN_W-1:0] LUMP_LEN = LEN_W'(LUMP_BYTES);

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_LUMP_LENGTH = 1'b0;

	// item kinds
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DIM  = 2'd1;
	localparam logic [1:0] ST_OUTSIDE  = 2'd2;
	localparam logic [1:0] ST_PAST_END = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [15:0] byte_address;
		logic [7:0]  byte_value;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} req_t;

	typedef struct packed {
		logic               opaque;
		logic [7:0]         color_index;
		logic [1:0]         status;
		logic signed [15:0] pic_width;
		logic signed [15:0] pic_height;
		logic signed [15:0] left_offset;
		logic signed [15:0] top_offset;
	} rsp_t;

	// core handshake status toward the top level
	typedef struct packed {
		logic ready;
		logic done;
	} ctl_t;

endpackage

### src/cppd_core.sv
`include "column_post_picture_decoder_unit_defines.svh"

module cppd_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      take,
	input  cppd_pkg::req_t            req,
	input  logic [cppd_pkg::LEN_W-1:0] len,
	output cppd_pkg::ctl_t            ctl,
	output cppd_pkg::rsp_t            res
);
	import cppd_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HDR   = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_OFS   = 4'd3;
	localparam logic [3:0] S_TOP   = 4'd4;
	localparam logic [3:0] S_TOPD  = 4'd5;
	localparam logic [3:0] S_CNT   = 4'd6;
	localparam logic [3:0] S_COL   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	localparam logic [3:0] HDR_BYTES = 4'd8;
	localparam logic [3:0] OFS_BYTES = 4'd4;
	localparam logic signed [15:0] MAX_DIM = 16'sd4096;
	localparam logic [7:0] POST_END = 8'hFF;

	logic [7:0]       mem [LUMP_BYTES];
	logic [7:0]       rdata_q;
	logic [3:0]       state_q;
	logic [3:0]       cnt_q;
	logic [63:0]      hdr_q;
	logic [31:0]      ofs_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       top_q;
	logic [11:0]      x_q;
	logic [11:0]      y_q;
	rsp_t             res_q;

	logic             rd_en;
	logic [POS_W-1:0] rd_pos;
	logic             wr_en;
	logic [POS_W-1:0] len_x;
	logic signed [15:0] w;
	logic signed [15:0] h;
	logic             dim_bad;
	logic             outside;
	logic [POS_W-1:0] ofs_pos;
	logic             ofs_fit;
	logic [31:0]      ofs_new;
	logic             top_in;
	logic             pad_fit;
	logic [POS_W-1:0] nxt_pos;
	logic             post_fit;
	logic [8:0]       top_end;
	logic             hit;
	logic [7:0]       dy;

	assign len_x = {1'b0, len};
	assign wr_en = start && (req.req_type == REQ_STORE);

	// header checks
	assign w       = hdr_q[15:0];
	assign h       = hdr_q[31:16];
	assign dim_bad = (w <= 16'sd0) || (h <= 16'sd0) || (w > MAX_DIM) || (h > MAX_DIM);
	assign outside = ({1'b0, x_q} >= w[12:0]) || ({1'b0, y_q} >= h[12:0]);
	assign ofs_pos = POS_W'({x_q, 2'b00}) + POS_W'(HDR_BYTES);
	assign ofs_fit = (ofs_pos + POS_W'(OFS_BYTES)) <= len_x;
	assign ofs_new = {rdata_q, ofs_q[31:8]};

	// post walk bounds: top delta, length, pad, indices, pad
	assign top_in   = pos_q < len_x;
	assign pad_fit  = (pos_q + POS_W'(3)) <= len_x;
	assign nxt_pos  = pos_q + POS_W'(4) + POS_W'(rdata_q);
	assign post_fit = nxt_pos <= len_x;
	assign top_end  = {1'b0, top_q} + {1'b0, rdata_q};
	assign hit      = (y_q >= 12'(top_q)) && (y_q < 12'(top_end));
	assign dy       = 8'(y_q - 12'(top_q));

	// read address issue
	always_comb begin
		rd_en  = 1'b0;
		rd_pos = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_en = start && (req.req_type == REQ_QUERY) && (len >= LEN_W'(HDR_BYTES));
			end
			S_HDR: begin
				rd_en  = cnt_q != HDR_BYTES;
				rd_pos = POS_W'(cnt_q);
			end
			S_CHECK: begin
				rd_en  = !dim_bad && !outside && ofs_fit;
				rd_pos = ofs_pos;
			end
			S_OFS: begin
				rd_en  = cnt_q != OFS_BYTES;
				rd_pos = pos_q + POS_W'(cnt_q);
			end
			S_TOP: begin
				rd_en  = top_in;
				rd_pos = pos_q;
			end
			S_TOPD: begin
				rd_en  = (rdata_q != POST_END) && pad_fit;
				rd_pos = pos_q + POS_W'(1);
			end
			S_CNT: begin
				rd_en  = post_fit && hit;
				rd_pos = pos_q + POS_W'(3) + POS_W'(dy);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// lump byte memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[req.byte_address] <= req.byte_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_pos[ADDR_W-1:0]];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.req_type == REQ_STORE || len < LEN_W'(HDR_BYTES)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_HDR;
						end
					end
				end
				S_HDR: begin
					if (cnt_q == HDR_BYTES) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (dim_bad || outside || !ofs_fit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_OFS;
					end
				end
				S_OFS: begin
					if (cnt_q == OFS_BYTES) begin
						if (ofs_new[31:LEN_W] != '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_TOP;
						end
					end
				end
				S_TOP: begin
					state_q <= top_in ? S_TOPD : S_DONE;
				end
				S_TOPD: begin
					if (rdata_q == POST_END || !pad_fit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					if (!post_fit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= hit ? S_COL : S_TOP;
					end
				end
				S_COL: begin
					state_q <= S_TOP;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_q.opaque      <= 1'b0;
					res_q.color_index <= '0;
					res_q.pic_width   <= '0;
					res_q.pic_height  <= '0;
					res_q.left_offset <= '0;
					res_q.top_offset  <= '0;
					x_q   <= req.pixel_x;
					y_q   <= req.pixel_y;
					cnt_q <= 4'd1;
					if (req.req_type == REQ_QUERY && len < LEN_W'(HDR_BYTES)) begin
						res_q.status <= ST_PAST_END;
					end else begin
						res_q.status <= ST_OK;
					end
				end
			end
			S_HDR: begin
				hdr_q <= {rdata_q, hdr_q[63:8]};
				cnt_q <= cnt_q + 4'd1;
			end
			S_CHECK: begin
				res_q.pic_width   <= hdr_q[15:0];
				res_q.pic_height  <= hdr_q[31:16];
				res_q.left_offset <= hdr_q[47:32];
				res_q.top_offset  <= hdr_q[63:48];
				pos_q             <= ofs_pos;
				cnt_q             <= 4'd1;
				if (dim_bad) begin
					res_q.status <= ST_BAD_DIM;
				end else if (outside) begin
					res_q.status <= ST_OUTSIDE;
				end else if (!ofs_fit) begin
					res_q.status <= ST_PAST_END;
				end
			end
			S_OFS: begin
				ofs_q <= ofs_new;
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == OFS_BYTES) begin
					pos_q <= POS_W'(ofs_new[LEN_W-1:0]);
					if (ofs_new[31:LEN_W] != '0) begin
						res_q.status <= ST_PAST_END;
					end
				end
			end
			S_TOP: begin
				if (!top_in) begin
					res_q.opaque      <= 1'b0;
					res_q.color_index <= '0;
					res_q.status      <= ST_PAST_END;
				end
			end
			S_TOPD: begin
				top_q <= rdata_q;
				if (rdata_q != POST_END && !pad_fit) begin
					res_q.opaque      <= 1'b0;
					res_q.color_index <= '0;
					res_q.status      <= ST_PAST_END;
				end
			end
			S_CNT: begin
				pos_q <= nxt_pos;
				if (!post_fit) begin
					res_q.opaque      <= 1'b0;
					res_q.color_index <= '0;
					res_q.status      <= ST_PAST_END;
				end
			end
			S_COL: begin
				res_q.opaque      <= 1'b1;
				res_q.color_index <= rdata_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign ctl.ready = state_q == S_IDLE;
	assign ctl.done  = state_q == S_DONE;
	assign res       = res_q;

	// checks
	`CPPD_ASSERT_IMP(a_read_in_lump, clk, arst_n, rd_en, rd_pos < len_x)
	`CPPD_ASSERT_IMP(a_start_when_idle, clk, arst_n, start, state_q == S_IDLE)
	`CPPD_ASSERT_IMP(a_fault_clear, clk, arst_n, (state_q == S_DONE) && (res_q.status != ST_OK), !res_q.opaque && (res_q.color_index == 8'd0))
	`CPPD_ASSERT_NXT(a_take_to_idle, clk, arst_n, (state_q == S_DONE) && take, state_q == S_IDLE)

endmodule

### src/column_post_picture_decoder_unit.sv
// a store item goes from idle straight to the done state and then loads the result register
// a query reads the header and the column offset, walks each post (reading its color byte when
// the post covers the row) up to the end marker, then loads the result register
// throughput: one item at a time, the next item is accepted the cycle after its result loads
// reset clears the control state and the lump length; lump bytes hold no reset value
module column_post_picture_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cppd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  cppd_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output cppd_pkg::rsp_t              rsp
);
	import cppd_pkg::*;

	logic [LEN_W-1:0] lump_q;
	logic [LEN_W-1:0] len;
	logic             reg_hit;
	logic             start;
	logic             take;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             core_res;
	ctl_t             core_ctl;

	// register file
	assign reg_hit = paddr[PADDR_W-1] == REG_LUMP_LENGTH;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? 32'(lump_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lump_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			lump_q <= pwdata[LEN_W-1:0];
		end
	end

	// usable length capped at the memory size
	assign len = (lump_q > LUMP_LEN) ? LUMP_LEN : lump_q;

	// item handshake
	assign req_ready = core_ctl.ready;
	assign start     = req_valid && core_ctl.ready;
	assign take      = core_ctl.done && (!rsp_valid_q || rsp_ready);

	cppd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.take   (take),
		.req    (req),
		.len    (len),
		.ctl    (core_ctl),
		.res    (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= core_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
